// ===== rtl/adsr_env_pkg.sv =====
// Shared constants, types and rate tables for the ADSR envelope generator.
// No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps
`default_nettype none

package adsr_env_pkg;

    localparam int unsigned FULL_SCALE  = 100;
    localparam int unsigned TICK_DIVIDE = 20;

    localparam int unsigned SampleWidth = 16;
    localparam int unsigned LevelWidth  = 9;
    localparam int unsigned TickWidth   = 8;
    localparam int unsigned PhaseWidth  = 3;
    localparam int unsigned StepWidth   = 8;
    localparam int unsigned SustWidth   = 8;
    localparam int unsigned IdxWidth    = 4;
    localparam int unsigned OpWidth     = 2;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CfgDataWidth = 8;
    localparam int unsigned OutDataWidth = 24;

    // sample * level, then an exact divide by FULL_SCALE via a rounded-up reciprocal
    localparam int unsigned ProdWidth  = SampleWidth + LevelWidth;
    localparam int unsigned RecipShift = ProdWidth + $clog2(FULL_SCALE);
    localparam int unsigned RecipWidth = ProdWidth + 2;
    localparam int unsigned BigWidth   = ProdWidth + RecipWidth;
    localparam logic [63:0] RecipFull  =
        ((64'd1 << RecipShift) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
    localparam logic [RecipWidth-1:0] RECIP = RecipFull[RecipWidth-1:0];

    localparam logic [PhaseWidth-1:0] PH_IDLE    = 3'd0;
    localparam logic [PhaseWidth-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PhaseWidth-1:0] PH_DECAY   = 3'd2;
    localparam logic [PhaseWidth-1:0] PH_SUSTAIN = 3'd3;
    localparam logic [PhaseWidth-1:0] PH_RELEASE = 3'd4;

    localparam logic [OpWidth-1:0] OP_SAMPLE   = 2'd0;
    localparam logic [OpWidth-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OpWidth-1:0] OP_NOTE_OFF = 2'd2;

    localparam logic [CfgIdxWidth-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_DECAY   = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_RELEASE = 2'd2;
    localparam logic [CfgIdxWidth-1:0] REG_SUSTAIN = 2'd3;

    localparam logic [SustWidth-1:0] SUSTAIN_RESET = 8'd70;
    localparam logic [LevelWidth-1:0] FullLevel = LevelWidth'(FULL_SCALE);
    localparam logic [TickWidth-1:0] TickLimit = TickWidth'(TICK_DIVIDE);

    typedef struct packed {
        logic [SampleWidth-1:0] sample;
        logic [LevelWidth-1:0]  level;
        logic [PhaseWidth-1:0]  phase;
    } env_beat_t;

    typedef struct packed {
        logic [PhaseWidth-1:0] phase;
        logic [LevelWidth-1:0] level;
        logic [TickWidth-1:0]  tick;
    } env_state_t;

    typedef struct packed {
        logic [IdxWidth-1:0]  attack_index;
        logic [IdxWidth-1:0]  decay_index;
        logic [IdxWidth-1:0]  release_index;
        logic [SustWidth-1:0] sustain_level;
    } env_cfg_t;

    function automatic logic [StepWidth-1:0] atk_step(input logic [IdxWidth-1:0] idx);
        logic [StepWidth-1:0] s;
        unique case (idx)
            4'd0:    s = StepWidth'(FULL_SCALE);
            4'd1:    s = 8'd30;
            4'd2:    s = 8'd20;
            4'd3:    s = 8'd15;
            4'd4:    s = 8'd12;
            4'd5:    s = 8'd11;
            4'd6:    s = 8'd10;
            4'd7:    s = 8'd9;
            4'd8:    s = 8'd8;
            4'd9:    s = 8'd7;
            4'd10:   s = 8'd6;
            4'd11:   s = 8'd5;
            4'd12:   s = 8'd4;
            4'd13:   s = 8'd3;
            4'd14:   s = 8'd2;
            default: s = 8'd1;
        endcase
        return s;
    endfunction

    function automatic logic [StepWidth-1:0] dec_step(input logic [IdxWidth-1:0] idx);
        logic [StepWidth-1:0] s;
        unique case (idx)
            4'd0:    s = 8'd100;
            4'd1:    s = 8'd50;
            4'd2:    s = 8'd30;
            4'd3:    s = 8'd25;
            4'd4:    s = 8'd20;
            4'd5:    s = 8'd17;
            4'd6:    s = 8'd15;
            4'd7:    s = 8'd12;
            4'd8:    s = 8'd10;
            4'd9:    s = 8'd9;
            4'd10:   s = 8'd8;
            4'd11:   s = 8'd7;
            4'd12:   s = 8'd5;
            4'd13:   s = 8'd3;
            4'd14:   s = 8'd2;
            default: s = 8'd1;
        endcase
        return s;
    endfunction

    function automatic logic [StepWidth-1:0] rel_step(input logic [IdxWidth-1:0] idx);
        logic [StepWidth-1:0] s;
        unique case (idx)
            4'd0:    s = StepWidth'(FULL_SCALE);
            4'd1:    s = 8'd15;
            4'd2:    s = 8'd14;
            4'd3:    s = 8'd13;
            4'd4:    s = 8'd12;
            4'd5:    s = 8'd11;
            4'd6:    s = 8'd10;
            4'd7:    s = 8'd9;
            4'd8:    s = 8'd8;
            4'd9:    s = 8'd7;
            4'd10:   s = 8'd6;
            4'd11:   s = 8'd5;
            4'd12:   s = 8'd4;
            4'd13:   s = 8'd3;
            4'd14:   s = 8'd2;
            default: s = 8'd1;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/adsr_env_state.sv =====
// Envelope state: phase, level and tick counter, updated once per accepted beat.
// Depends on adsr_env_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adsr_env_state (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            fire,
    input  wire logic [adsr_env_pkg::OpWidth-1:0]     op,
    input  wire logic [adsr_env_pkg::SampleWidth-1:0] sample,
    input  wire adsr_env_pkg::env_cfg_t          cfg,
    output adsr_env_pkg::env_beat_t              beat,
    output logic                                 emit,
    output adsr_env_pkg::env_state_t             status
);
    import adsr_env_pkg::*;

    env_state_t st_reg;
    env_state_t st_next;
    env_state_t ticked;
    logic [StepWidth-1:0] a_step;
    logic [StepWidth-1:0] d_step;
    logic [StepWidth-1:0] r_step;

    assign a_step = atk_step(cfg.attack_index);
    assign d_step = dec_step(cfg.decay_index);
    assign r_step = rel_step(cfg.release_index);

    // one envelope tick applied to the current state
    always_comb
    begin
        ticked = st_reg;
        if (st_reg.tick >= TickLimit)
        begin
            ticked.tick = '0;
            priority if (st_reg.phase == PH_ATTACK)
            begin
                if (st_reg.level < FullLevel)
                begin
                    ticked.level = st_reg.level + {1'b0, a_step};
                end
                else
                begin
                    ticked.level = FullLevel;
                    ticked.phase = PH_DECAY;
                end
            end
            else if (st_reg.phase == PH_DECAY)
            begin
                if (st_reg.level >= {1'b0, cfg.sustain_level})
                begin
                    ticked.level = (st_reg.level > {1'b0, d_step}) ?
                                   st_reg.level - {1'b0, d_step} : '0;
                end
                else
                begin
                    ticked.level = {1'b0, cfg.sustain_level};
                    ticked.phase = PH_SUSTAIN;
                end
            end
            else if (st_reg.phase == PH_RELEASE)
            begin
                if ({1'b0, st_reg.level} > {1'b0, r_step, 1'b0})
                begin
                    ticked.level = st_reg.level - {1'b0, r_step};
                end
                else
                begin
                    ticked.phase = PH_IDLE;
                end
            end
            else
            begin
                ticked.level = st_reg.level;
            end
        end
        else
        begin
            ticked.tick = st_reg.tick + 1'b1;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        emit    = 1'b0;
        if (fire)
        begin
            unique case (op)
                OP_NOTE_ON:
                begin
                    st_next.phase = PH_ATTACK;
                    st_next.level = '0;
                    st_next.tick  = '0;
                end
                OP_NOTE_OFF:
                begin
                    if (st_reg.phase == PH_ATTACK || st_reg.phase == PH_DECAY ||
                        st_reg.phase == PH_SUSTAIN)
                    begin
                        st_next.phase = PH_RELEASE;
                    end
                end
                OP_SAMPLE:
                begin
                    st_next = ticked;
                    emit    = 1'b1;
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end
    end

    assign beat.sample = sample;
    assign beat.level  = ticked.level;
    assign beat.phase  = ticked.phase;
    assign status      = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase <= PH_IDLE;
            st_reg.level <= '0;
            st_reg.tick  <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adsr_env_scale.sv =====
// Sample scaling pipeline: sample * level, exact divide by full scale, saturate.
// Depends on adsr_env_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adsr_env_scale (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire adsr_env_pkg::env_beat_t  beat,
    output logic                          ready,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [adsr_env_pkg::SampleWidth-1:0] sample_out,
    output logic [adsr_env_pkg::PhaseWidth-1:0]  phase_out
);
    import adsr_env_pkg::*;

    logic v0_reg, v1_reg;
    logic rdy0, rdy1;

    env_beat_t              b0_reg;
    logic [ProdWidth-1:0]   prod;
    logic [BigWidth-1:0]    big;
    logic [PhaseWidth-1:0]  ph1_reg;
    logic [SampleWidth-1:0] out_reg;
    logic [63:0]            quot;

    // each stage moves when it is empty or the next one moves
    assign rdy1 = !v1_reg || out_ready;
    assign rdy0 = !v0_reg || rdy1;
    assign ready = rdy0;

    // input register to result register in one pass: product, reciprocal scale
    assign prod = ProdWidth'(b0_reg.sample) * ProdWidth'(b0_reg.level);
    assign big  = BigWidth'(prod) * BigWidth'(RECIP);
    assign quot = 64'(big) >> RecipShift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= load;
            if (rdy1) v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && load)
        begin
            b0_reg <= beat;
        end
        if (rdy1 && v0_reg)
        begin
            out_reg <= (|quot[63:SampleWidth]) ? '1 : quot[SampleWidth-1:0];
            ph1_reg <= b0_reg.phase;
        end
    end

    assign out_valid  = v1_reg;
    assign sample_out = out_reg;
    assign phase_out  = ph1_reg;

endmodule

`default_nettype wire

// ===== rtl/adsr_envelope_generator_top.sv =====
// ADSR envelope generator top: stream ports, config registers, state and scaler.
// Depends on adsr_env_pkg, adsr_env_state and adsr_env_scale.
// A sample beat's result passes the input register, then the result register, before it leaves.
// One beat per cycle unless the output is held; input and result register each with flow control.
// Note beats update state at acceptance; unused-op beats do not; neither gives an output beat.
// Reset (rst_n, async low): phase idle, level and tick 0, indexes 0, sustain 70, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module adsr_envelope_generator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample_in
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [15:0] sample_out, [18:16] phase_now, rest zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import adsr_env_pkg::*;

    env_cfg_t   cfg_reg;
    env_beat_t  beat;
    env_state_t status;
    logic       emit;
    logic       fire;
    logic [SampleWidth-1:0] sample_out;
    logic [PhaseWidth-1:0]  phase_now;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_index  <= '0;
            cfg_reg.decay_index   <= '0;
            cfg_reg.release_index <= '0;
            cfg_reg.sustain_level <= SUSTAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ATTACK:  cfg_reg.attack_index  <= cfg_data[IdxWidth-1:0];
                REG_DECAY:   cfg_reg.decay_index   <= cfg_data[IdxWidth-1:0];
                REG_RELEASE: cfg_reg.release_index <= cfg_data[IdxWidth-1:0];
                REG_SUSTAIN: cfg_reg.sustain_level <= cfg_data;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign fire = s_tvalid && s_tready;

    adsr_env_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .op     (s_tuser),
        .sample (s_tdata),
        .cfg    (cfg_reg),
        .beat   (beat),
        .emit   (emit),
        .status (status)
    );

    adsr_env_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .beat       (beat),
        .ready      (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .sample_out (sample_out),
        .phase_out  (phase_now)
    );

    assign m_tdata = {{(OutDataWidth - SampleWidth - PhaseWidth){1'b0}}, phase_now, sample_out};

    // input side only stalls when every scaler stage is full and the output is held
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_note_on: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s_tuser == OP_NOTE_ON) |=>
        (status.phase == PH_ATTACK && status.level == '0 && status.tick == '0))
        else $error("note-on did not restart the envelope");

    a_release_level: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s_tuser == OP_NOTE_OFF && status.phase != PH_IDLE) |=>
        (status.phase == PH_RELEASE && $stable(status.level)))
        else $error("note-off did not enter release with level kept");

endmodule

`default_nettype wire
